// ===== rtl/fla_pkg.sv =====
// Shared types, field widths and codes for the free list slot allocator.
package fla_pkg;

    localparam int DEF_POOL_SLOTS = 64;

    localparam int SLOT_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        CTRL_CLEAR,
        CTRL_SETTLE,
        CTRL_IDLE
    } fla_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic take;
    } fla_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } fla_sts_t;

endpackage

// ===== rtl/fla_ctrl.sv =====
// Controller state machine: link table initialisation, transaction accept and settle.
module fla_ctrl
    import fla_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  fla_sts_t sts,
    output fla_cmd_t cmd
);

    fla_state_t state_reg;
    fla_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            CTRL_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = CTRL_SETTLE;
                end
            end
            // let the head's link read catch up with the last update
            CTRL_SETTLE:
            begin
                state_next = CTRL_IDLE;
            end
            CTRL_IDLE:
            begin
                s_tready = sts.out_free;
                cmd.take = sts.out_free && s_tvalid;
                if (cmd.take)
                begin
                    state_next = CTRL_SETTLE;
                end
            end
            default:
            begin
                state_next = CTRL_CLEAR;
            end
        endcase
    end

    a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    a_clear_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> (!s_tready && !cmd.take))
        else $error("transaction accepted during table initialisation");

endmodule

// ===== rtl/fla_dp.sv =====
// Datapath: link table memory, head and count registers, result register.
module fla_dp
    import fla_pkg::*;
#(
    parameter int POOL_SLOTS = DEF_POOL_SLOTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  fla_cmd_t               cmd,
    output fla_sts_t               sts,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam logic [LW-1:0] END_MARK = LW'(POOL_SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_SLOTS - 1);

    logic [LW-1:0] link_mem [POOL_SLOTS];
    logic [LW-1:0] rd_data_reg;

    logic [LW-1:0] head_reg;
    logic [LW-1:0] head_next;
    logic [LW-1:0] cnt_reg;
    logic [LW-1:0] cnt_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [LW-1:0]       mem_wdata;

    logic                action;
    logic [SLOT_W-1:0]   slot;
    logic                slot_ok;
    logic                empty;
    logic [SLOT_W-1:0]   granted;
    logic [STATUS_W-1:0] status;

    assign action  = s_tdata[0];
    assign slot    = s_tdata[SLOT_W:1];
    assign slot_ok = (32'(slot) < POOL_SLOTS);
    assign empty   = (head_reg == END_MARK);

    assign sts.clr_last = (clr_addr_reg == LAST_ADDR);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = AW'(slot);
        mem_wdata     = head_reg;
        granted       = '0;
        status        = ST_RELEASED;

        if (cmd.clr_wr)
        begin
            mem_we        = 1'b1;
            mem_waddr     = clr_addr_reg;
            mem_wdata     = sts.clr_last ? END_MARK : LW'(clr_addr_reg) + LW'(1);
            clr_addr_next = clr_addr_reg + AW'(1);
        end

        if (action == ACT_ALLOC)
        begin
            if (empty)
            begin
                status = ST_EMPTY;
            end
            else
            begin
                status  = ST_GRANTED;
                granted = SLOT_W'(head_reg);
                if (cmd.take)
                begin
                    head_next = rd_data_reg;
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - LW'(1);
                    end
                end
            end
        end
        else if (cmd.take && slot_ok)
        begin
            // push the released slot onto the head
            mem_we    = 1'b1;
            head_next = LW'(slot);
            if (cnt_reg != END_MARK)
            begin
                cnt_next = cnt_reg + LW'(1);
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (cmd.take)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, COUNT_W'(cnt_next), status, granted};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            cnt_reg      <= END_MARK;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // Read the head's link every cycle; the registered value is valid in the cycle after the head settles
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= link_mem[AW'(head_reg)];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= END_MARK)
        else $error("free count above pool size");

    a_take_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> m_tvalid_reg)
        else $error("accepted transaction produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

// ===== rtl/free_list_slot_allocator.sv =====
// Top level of the free list slot allocator: controller and datapath.
//
// Requests arrive on the s_ stream: action 0 allocates the head slot of the
// free list, action 1 pushes slot_index back onto the head. Each request
// gives exactly one result on the m_ stream: the granted slot (0 unless
// granted), a status (granted, pool empty, released) and the free count.
// When a request is taken, its result sits in the output register in the
// following cycle; the controller then passes through the settle state
// while the link of the new head is read from the synchronous link memory,
// so the block does not accept a new request in the settle state.
// After reset the link memory is initialised one entry per cycle, slot i
// linking to i+1 and the last slot to the end mark; s_tready stays low
// during initialisation and the settle state after it. A result waiting on a
// stalled m_tready is held; the next request is taken in the cycle the
// pending result drains, and is refused while the result stays stalled.
module free_list_slot_allocator
    import fla_pkg::*;
#(
    parameter int POOL_SLOTS = DEF_POOL_SLOTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // action[0], slot_index[6:1], zero[7]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // granted_slot[5:0], status[7:6],
                                              // free_count[14:8], zero[15]
);

    fla_cmd_t cmd;
    fla_sts_t sts;

    fla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fla_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
